FILE: rtl/core/spao_pkg.sv
// Package for the sine phase-accumulator oscillator: table geometry, field widths,
// register codes, the config write bundle, queue status and the sine ROM contents.
// No dependencies.
package spao_pkg;

  localparam int TABLE_POINTS = 512;
  localparam int IDX_W        = $clog2(TABLE_POINTS);
  localparam int STEP_W       = 25;
  localparam int START_W      = 9;
  localparam int SAMPLE_W     = 16;
  localparam int CFG_DATA_W   = 25;
  localparam int QUEUE_DEPTH  = 2;

  localparam longint unsigned ONE_Q30     = 64'd1 << 30;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  typedef enum logic [0:0] {
    REG_PHASE_STEP  = 1'b0,
    REG_START_PHASE = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic                  we;
    reg_idx_t              index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef logic signed [SAMPLE_W-1:0] sine_tab_t [TABLE_POINTS];

  // One Taylor step: multiply the running term by x twice, Q30 each time
  function automatic longint unsigned taylor_term(longint unsigned t, longint unsigned x);
    longint unsigned p;
    p = (t * x) >> 30;
    p = (p * x) >> 30;
    return p;
  endfunction

  // sin(x) in Q30 for x in [0, pi/2] given in Q30, series up to the x^17 term
  function automatic longint unsigned sin_q30(longint unsigned x);
    longint unsigned term;
    longint          sum;
    term = x;
    sum  = longint'(x);
    term = taylor_term(term, x) / 64'd6;   sum = sum - longint'(term);
    term = taylor_term(term, x) / 64'd20;  sum = sum + longint'(term);
    term = taylor_term(term, x) / 64'd42;  sum = sum - longint'(term);
    term = taylor_term(term, x) / 64'd72;  sum = sum + longint'(term);
    term = taylor_term(term, x) / 64'd110; sum = sum - longint'(term);
    term = taylor_term(term, x) / 64'd156; sum = sum + longint'(term);
    term = taylor_term(term, x) / 64'd210; sum = sum - longint'(term);
    term = taylor_term(term, x) / 64'd272; sum = sum + longint'(term);
    if (sum < 0) sum = 0;
    if (sum > longint'(ONE_Q30)) sum = longint'(ONE_Q30);
    return longint'(sum);
  endfunction

  function automatic sine_tab_t build_sine_tab();
    sine_tab_t       tab;
    longint unsigned k4;
    longint unsigned quad;
    longint unsigned rem;
    longint unsigned x;
    longint unsigned s;
    longint unsigned mag;
    for (int k = 0; k < TABLE_POINTS; k++) begin
      k4   = 64'(k) * 64'd4;
      quad = k4 / TABLE_POINTS;
      rem  = k4 % TABLE_POINTS;
      // mirror odd quadrants
      if (quad[0]) rem = TABLE_POINTS - rem;
      x    = rem * HALF_PI_Q30 / TABLE_POINTS;
      s    = sin_q30(x);
      mag  = (s * 64'd32767 + (ONE_Q30 >> 1)) >> 30;
      tab[k] = (quad >= 2) ? -SAMPLE_W'(mag) : SAMPLE_W'(mag);
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine_tab();

endpackage

FILE: rtl/core/spao_in_if.sv
// Tick channel of the oscillator: valid/ready handshake with the restart flag.
// No dependencies.
interface spao_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

FILE: rtl/core/spao_out_if.sv
// Sample channel of the oscillator: valid/ready handshake with a signed Q1.15 sample.
// Depends on spao_pkg for the sample width.
interface spao_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [spao_pkg::SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

FILE: rtl/core/spao_queue.sv
// Short register FIFO that carries accumulated phases from the front to the back.
// Depends on spao_pkg for depth and status type.
module spao_queue #(
  parameter int WIDTH = 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  logic [WIDTH-1:0]      push_data,
  input  logic                  pop,
  output logic [WIDTH-1:0]      pop_data,
  output spao_pkg::q_status_t   status
);

  localparam int PTR_W = $clog2(spao_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(spao_pkg::QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] mem_r [spao_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;

  assign status.full  = (count_r == CNT_W'(spao_pkg::QUEUE_DEPTH));
  assign status.empty = (count_r == '0);
  assign pop_data     = mem_r[rd_ptr_r];

  always_comb begin
    case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) wr_ptr_r <= PTR_W'(wr_ptr_r + 1'b1);
      if (pop)  rd_ptr_r <= PTR_W'(rd_ptr_r + 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

endmodule

FILE: rtl/core/spao_front.sv
// Front end: configuration registers and the phase accumulator; accepts ticks,
// applies restart and step, and pushes each new phase into the queue.
// Depends on spao_pkg and spao_in_if.
module spao_front #(
  parameter int FRAC_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  spao_in_if.sink                            in_ch,
  input  spao_pkg::cfg_wr_t                  cfg,
  input  spao_pkg::q_status_t                q_status,
  output logic                               push,
  output logic [spao_pkg::IDX_W+FRAC_BITS-1:0] push_phase
);

  localparam int PW    = spao_pkg::IDX_W + FRAC_BITS;
  localparam int EXT_W = (PW > spao_pkg::STEP_W) ? PW : spao_pkg::STEP_W;

  logic [spao_pkg::STEP_W-1:0]  step_r;
  logic [spao_pkg::START_W-1:0] start_r;
  logic [PW-1:0]                phase_r;
  logic [PW-1:0]                phase_nxt;
  logic [PW-1:0]                base;
  logic [EXT_W-1:0]             step_ext;
  logic                         accept;

  assign in_ch.ready = !q_status.full;
  assign accept      = in_ch.valid && in_ch.ready;

  // step taken modulo the phase range
  assign step_ext  = EXT_W'(step_r);
  assign base      = in_ch.restart ? {spao_pkg::IDX_W'(start_r), FRAC_BITS'(0)} : phase_r;
  assign phase_nxt = base + step_ext[PW-1:0];

  assign push       = accept;
  assign push_phase = phase_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r  <= '0;
      start_r <= '0;
      phase_r <= '0;
    end else begin
      if (cfg.we) begin
        unique case (cfg.index)
          spao_pkg::REG_PHASE_STEP:  step_r  <= cfg.data[spao_pkg::STEP_W-1:0];
          spao_pkg::REG_START_PHASE: start_r <= cfg.data[spao_pkg::START_W-1:0];
          default: ;
        endcase
      end
      if (accept) phase_r <= phase_nxt;
    end
  end

endmodule

FILE: rtl/core/spao_back.sv
// Back end: pops phases, reads the sine ROM at the point and its neighbor,
// interpolates with one multiply and holds the sample in the output register.
// Depends on spao_pkg and spao_out_if.
module spao_back #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  spao_pkg::q_status_t                  q_status,
  input  logic [spao_pkg::IDX_W+FRAC_BITS-1:0] q_phase,
  output logic                                 pop,
  spao_out_if.source                           out_ch
);

  localparam int PW     = spao_pkg::IDX_W + FRAC_BITS;
  localparam int SW     = spao_pkg::SAMPLE_W;
  localparam int DIFF_W = SW + 1;
  localparam int PRW    = DIFF_W + FRAC_BITS + 1;
  localparam int unsigned HALF = 1 << (FRAC_BITS - 1);

  logic [spao_pkg::IDX_W-1:0] idx;
  logic [spao_pkg::IDX_W-1:0] nxt;

  logic                  s1_v_r;
  logic signed [SW-1:0]  a_r;
  logic signed [SW-1:0]  b_r;
  logic [FRAC_BITS-1:0]  frac_r;

  logic                  s2_v_r;
  logic signed [SW-1:0]  a2_r;
  logic signed [PRW-1:0] prod_r;

  logic                  out_v_r;
  logic signed [SW-1:0]  sample_r;

  logic                    s1_ready;
  logic                    s2_ready;
  logic                    o_ready;
  logic signed [DIFF_W-1:0] diff;
  logic signed [FRAC_BITS:0] frac_s;
  logic signed [PRW-1:0]   prod_nxt;
  logic signed [PRW-1:0]   rnd;
  logic signed [PRW-1:0]   shifted;
  logic [DIFF_W-1:0]       interp;
  logic [SW-1:0]           sample_nxt;

  assign o_ready  = !out_v_r || out_ch.ready;
  assign s2_ready = !s2_v_r || o_ready;
  assign s1_ready = !s1_v_r || s2_ready;
  assign pop      = s1_ready && !q_status.empty;

  // next point wraps to entry 0 through the index width
  assign idx = q_phase[PW-1:FRAC_BITS];
  assign nxt = spao_pkg::IDX_W'(idx + 1'b1);

  // a*(1-f) + b*f rewritten as a + (b-a)*f
  assign diff     = DIFF_W'(b_r) - DIFF_W'(a_r);
  assign frac_s   = {1'b0, frac_r};
  assign prod_nxt = diff * frac_s;

  // round half up: add half, then floor through the arithmetic shift
  assign rnd        = prod_r + $signed(PRW'(HALF));
  assign shifted    = rnd >>> FRAC_BITS;
  assign interp     = shifted[DIFF_W-1:0];
  assign sample_nxt = SW'(DIFF_W'(a2_r) + interp);

  assign out_ch.valid  = out_v_r;
  assign out_ch.sample = sample_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (s1_ready) s1_v_r  <= !q_status.empty;
      if (s2_ready) s2_v_r  <= s1_v_r;
      if (o_ready)  out_v_r <= s2_v_r;
    end
  end

  // ROM read ports, registered
  always_ff @(posedge clk) begin
    if (pop) begin
      a_r    <= spao_pkg::SINE_TAB[idx];
      b_r    <= spao_pkg::SINE_TAB[nxt];
      frac_r <= q_phase[FRAC_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_v_r) begin
      prod_r <= prod_nxt;
      a2_r   <= a_r;
    end
    if (o_ready && s2_v_r) sample_r <= SW'(sample_nxt);
  end

`ifndef SYNTH
  a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_status.empty)
    else $error("pop from empty phase queue");

  a_pop_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> s1_v_r)
    else $error("popped phase did not reach the ROM stage");

  a_s2_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_v_r && !s2_ready) |=> (s2_v_r && $stable(prod_r) && $stable(a2_r)))
    else $error("stalled multiply stage lost its product");

  a_sample_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> (sample_r != {1'b1, {(SW-1){1'b0}}}))
    else $error("sample left the range of the sine table");
`endif

endmodule

FILE: rtl/core/sine_phase_accumulator_oscillator_top.sv
// Sine oscillator by direct digital synthesis with linear interpolation: top level.
// Depends on spao_pkg, spao_in_if, spao_out_if, spao_front, spao_queue, spao_back.
//
// Each accepted tick transaction adds phase_step (Q9.FRAC_BITS table points) to the
// phase accumulator, after reloading start_phase when restart is set, and yields one
// signed Q1.15 sample interpolated between the 512-point sine table entry at the
// integer phase and the next entry. The block takes one tick per clock cycle and
// returns one sample per clock cycle while the sample channel is ready; the rate is
// set by the two-port registered sine ROM read and the single interpolation
// multiplier, each one pipeline stage. An accepted tick's phase passes the queue, the ROM
// stage, the multiply stage and the output register. A two-entry phase queue decouples
// the accumulator from the interpolation pipeline, so ticks keep being taken while a
// sample waits, until the queue is full. Register 0 is phase_step (25 bits), register
// 1 is start_phase (9 bits); write them only while no transaction is in flight.
module sine_phase_accumulator_oscillator_top #(
  parameter int FRAC_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  spao_in_if.sink                         in_ch,
  spao_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  spao_pkg::reg_idx_t              cfg_index,
  input  logic [spao_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int PW = spao_pkg::IDX_W + FRAC_BITS;

  spao_pkg::cfg_wr_t   cfg;
  spao_pkg::q_status_t q_status;
  logic                push;
  logic                pop;
  logic [PW-1:0]       push_phase;
  logic [PW-1:0]       pop_phase;

  assign cfg.we    = cfg_we;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  spao_front #(
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .cfg        (cfg),
    .q_status   (q_status),
    .push       (push),
    .push_phase (push_phase)
  );

  spao_queue #(
    .WIDTH (PW)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_phase),
    .pop       (pop),
    .pop_data  (pop_phase),
    .status    (q_status)
  );

  spao_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_status (q_status),
    .q_phase  (pop_phase),
    .pop      (pop),
    .out_ch   (out_ch)
  );

endmodule
